@@ rtl/core/srw_pkg.sv @@
// Package for the sequence reorder window: window depth, status and op codes,
// word structs and circular-pointer helpers. No dependencies.
`default_nettype none

package srw_pkg;

  localparam int DEPTH  = 16;
  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PTR_W1 = PTR_W + 1;

  typedef logic [PTR_W-1:0] ptr_t;

  // op codes
  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_SET  = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  // status codes
  localparam logic [2:0] ST_POPPED   = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_STORED   = 3'd2;
  localparam logic [2:0] ST_ADVANCED = 3'd3;
  localparam logic [2:0] ST_LATE     = 3'd4;
  localparam logic [2:0] ST_DISABLED = 3'd5;
  localparam logic [2:0] ST_BASESET  = 3'd6;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] seq;
    logic [31:0] payload;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] out_payload;
    logic [31:0] out_seq;
  } rsp_t;

  // (a + b) mod DEPTH, both operands below DEPTH
  function automatic ptr_t ptr_add(input ptr_t a, input ptr_t b);
    logic [PTR_W1-1:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= PTR_W1'(DEPTH)) s = s - PTR_W1'(DEPTH);
    return s[PTR_W-1:0];
  endfunction

  // (p - h) mod DEPTH: logical position of physical slot p for head h
  function automatic ptr_t ptr_sub(input ptr_t p, input ptr_t h);
    logic [PTR_W1-1:0] s;
    s = {1'b0, p} + PTR_W1'(DEPTH) - {1'b0, h};
    if (s >= PTR_W1'(DEPTH)) s = s - PTR_W1'(DEPTH);
    return s[PTR_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/srw_window.sv @@
// Window state and single-pass update: base, circular head pointer, slot
// valid bits, slot data memory, result register. Depends on srw_pkg.
`default_nettype none

module srw_window (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          item_valid,
  input  wire srw_pkg::cmd_t item,
  input  wire logic          enabled,
  output logic               done,
  output srw_pkg::rsp_t      rsp
);

  logic [31:0]                base;
  srw_pkg::ptr_t              head;
  logic [srw_pkg::DEPTH-1:0]  slot_valid;
  logic [31:0]                mem [srw_pkg::DEPTH];
  logic [31:0]                rd_data;
  logic                       pop_hit;
  logic [2:0]                 status_q;
  logic [31:0]                oseq_q;

  logic [31:0]                base_next;
  srw_pkg::ptr_t              head_next;
  logic [srw_pkg::DEPTH-1:0]  valid_next;
  logic [2:0]                 status_next;
  logic [31:0]                oseq_next;
  logic                       hit_next;
  logic                       we;
  srw_pkg::ptr_t              waddr;

  logic [31:0]                off;
  logic [31:0]                over;
  logic                       wipe;
  srw_pkg::ptr_t              adv_head;
  srw_pkg::ptr_t              tail;
  srw_pkg::ptr_t              lpos [srw_pkg::DEPTH];

  assign off      = item.seq - base;
  assign over     = off - 32'(srw_pkg::DEPTH - 1);
  assign wipe     = off >= 32'(2 * srw_pkg::DEPTH - 1);
  assign adv_head = wipe ? head : srw_pkg::ptr_add(head, over[srw_pkg::PTR_W-1:0]);
  assign tail     = srw_pkg::ptr_add(head, srw_pkg::ptr_t'(srw_pkg::DEPTH - 1));

  // logical position of each physical slot
  always_comb begin
    for (int p = 0; p < srw_pkg::DEPTH; p++) begin
      lpos[p] = srw_pkg::ptr_sub(srw_pkg::ptr_t'(p), head);
    end
  end

  always_comb begin
    base_next   = base;
    head_next   = head;
    valid_next  = slot_valid;
    status_next = srw_pkg::ST_EMPTY;
    oseq_next   = '0;
    hit_next    = 1'b0;
    we          = 1'b0;
    waddr       = srw_pkg::ptr_add(head, off[srw_pkg::PTR_W-1:0]);
    if (item.op == srw_pkg::OP_SET) begin
      base_next   = item.seq;
      status_next = srw_pkg::ST_BASESET;
    end else if (item.op == srw_pkg::OP_NONE) begin
      status_next = srw_pkg::ST_EMPTY;
    end else if (!enabled) begin
      status_next = srw_pkg::ST_DISABLED;
    end else if (item.op == srw_pkg::OP_PUSH) begin
      if (off[31]) begin
        status_next = srw_pkg::ST_LATE;
      end else if (off >= 32'(srw_pkg::DEPTH)) begin
        // advance: drop entries that fall below the new base
        for (int p = 0; p < srw_pkg::DEPTH; p++) begin
          if (wipe || (32'(lpos[p]) < over)) valid_next[p] = 1'b0;
        end
        base_next   = base + over;
        head_next   = adv_head;
        waddr       = srw_pkg::ptr_add(adv_head, srw_pkg::ptr_t'(srw_pkg::DEPTH - 1));
        valid_next[waddr] = 1'b1;
        we          = 1'b1;
        status_next = srw_pkg::ST_ADVANCED;
      end else begin
        valid_next[waddr] = 1'b1;
        we          = 1'b1;
        status_next = srw_pkg::ST_STORED;
      end
    end else begin
      oseq_next = base;
      if (slot_valid[head]) begin
        hit_next         = 1'b1;
        valid_next[head] = 1'b0;
        head_next        = srw_pkg::ptr_add(head, srw_pkg::ptr_t'(1));
        base_next        = base + 32'd1;
        status_next      = srw_pkg::ST_POPPED;
      end else begin
        status_next = srw_pkg::ST_EMPTY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base       <= '0;
      head       <= '0;
      slot_valid <= '0;
      done       <= 1'b0;
      pop_hit    <= 1'b0;
    end else begin
      done <= item_valid;
      if (item_valid) begin
        base       <= base_next;
        head       <= head_next;
        slot_valid <= valid_next;
        pop_hit    <= hit_next;
      end
    end
  end

  // result fields and slot data memory (registered read at head)
  always_ff @(posedge clk) begin
    if (item_valid) begin
      status_q <= status_next;
      oseq_q   <= oseq_next;
      rd_data  <= mem[head];
      if (we) mem[waddr] <= item.payload;
    end
  end

  assign rsp.status      = status_q;
  assign rsp.out_payload = pop_hit ? rd_data : 32'd0;
  assign rsp.out_seq     = oseq_q;

  a_done_follows_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(item_valid))
    else $error("result strobe without a word in the input register");

  a_pop_bumps_base: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == srw_pkg::ST_POPPED) |-> (base == rsp.out_seq + 32'd1))
    else $error("pop did not advance the base by one");

  a_late_keeps_slots: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == srw_pkg::ST_LATE) |-> (slot_valid == $past(slot_valid)))
    else $error("late drop changed the window");

  a_advance_fills_tail: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == srw_pkg::ST_ADVANCED) |-> slot_valid[tail])
    else $error("advance left the last slot empty");

endmodule

`default_nettype wire

@@ rtl/core/sequence_reorder_window_top.sv @@
// Sequence reorder window top: command input register, enable register and
// the window core. Depends on srw_pkg and srw_window.
//
// Path: a word taken into the input register passes the window's result register
//   next, and its result then shows on rsp with done high.
// Throughput: one word per cycle; busy never rises, the single-pass window
//   update finishes within the cycle after the input register.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset (rst, sync, active high): window empty, base 0, head 0, enabled 1.
`default_nettype none

module sequence_reorder_window_top (
  input  wire logic          clk,
  input  wire logic          rst,
  // command channel
  input  wire logic          start,
  output logic               busy,
  input  wire srw_pkg::cmd_t cmd,
  // result channel
  output logic               done,
  output srw_pkg::rsp_t      rsp,
  // enable register write channel
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic          cfg_data
);

  logic          cmd_valid;  // input register holds a word
  srw_pkg::cmd_t cmd_q;
  logic          enabled;

  // Every word is taken; window state settles in one pass so the next word
  // sees it at once.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      cmd_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) cmd_q <= cmd;
  end

  // enable register; the user must write it only while no word is in flight (not enforced here)
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      enabled <= cfg_data;
    end
  end

  srw_window u_window (
    .clk        (clk),
    .rst        (rst),
    .item_valid (cmd_valid),
    .item       (cmd_q),
    .enabled    (enabled),
    .done       (done),
    .rsp        (rsp)
  );

endmodule

`default_nettype wire
